// ===== design/vgarpf_pkg.sv =====
// Package for the VGA register port file.
// Bank sizes, register file map, port offsets and shared types.
// No dependencies.
`default_nettype none

package vgarpf_pkg;

	localparam int SEQ_COUNT     = 5;
	localparam int CRTC_COUNT    = 25;
	localparam int GC_COUNT      = 9;
	localparam int ATTR_COUNT    = 21;
	localparam int PALETTE_DEPTH = 256;

	// register file map: one memory holds all indexed banks
	localparam int SEQ_BASE  = 0;
	localparam int CRTC_BASE = SEQ_BASE + SEQ_COUNT;
	localparam int GC_BASE   = CRTC_BASE + CRTC_COUNT;
	localparam int ATTR_BASE = GC_BASE + GC_COUNT;
	localparam int REG_TOTAL = ATTR_BASE + ATTR_COUNT;
	localparam int REG_AW    = $clog2(REG_TOTAL);
	localparam int PAL_AW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	localparam int PORT_W  = 5;
	localparam int DATA_W  = 8;
	localparam int COMP_W  = 6;
	localparam int ATTR_IW = 6;

	localparam logic [DATA_W-1:0] CRTC_PROTECT_REG = 8'h11;
	localparam int                CRTC_PROTECT_BIT = 7;
	localparam logic [DATA_W-1:0] CRTC_LOCK_LIMIT  = 8'h08;
	localparam bit CRTC_LOCK_EN = (CRTC_COUNT > 'h11);

	localparam logic [PORT_W-1:0] PORT_ATTR      = 5'h00;
	localparam logic [PORT_W-1:0] PORT_ATTR_DATA = 5'h01;
	localparam logic [PORT_W-1:0] PORT_MISC_WR   = 5'h02;
	localparam logic [PORT_W-1:0] PORT_SEQ_IDX   = 5'h04;
	localparam logic [PORT_W-1:0] PORT_SEQ_DATA  = 5'h05;
	localparam logic [PORT_W-1:0] PORT_DAC_WIDX  = 5'h08;
	localparam logic [PORT_W-1:0] PORT_DAC_DATA  = 5'h09;
	localparam logic [PORT_W-1:0] PORT_MISC_RD   = 5'h0C;
	localparam logic [PORT_W-1:0] PORT_GC_IDX    = 5'h0E;
	localparam logic [PORT_W-1:0] PORT_GC_DATA   = 5'h0F;
	localparam logic [PORT_W-1:0] PORT_CRTC_IDX  = 5'h14;
	localparam logic [PORT_W-1:0] PORT_CRTC_DATA = 5'h15;
	localparam logic [PORT_W-1:0] PORT_STATUS1   = 5'h1A;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef enum logic [1:0] {
		DAC_RED   = 2'd0,
		DAC_GREEN = 2'd1,
		DAC_BLUE  = 2'd2
	} dac_comp_t;

	// item in flight between the memory read and the output register
	typedef struct packed {
		logic              from_mem;
		logic              hit;
		logic              dec;
		logic [DATA_W-1:0] direct;
	} s1_info_t;

endpackage

`default_nettype wire

// ===== design/vgarpf_req_if.sv =====
// Request channel of the VGA register port file: one bus access per item.
// Depends on vgarpf_pkg.
`default_nettype none

interface vgarpf_req_if;
	import vgarpf_pkg::*;

	logic              valid;
	logic              ready;
	logic              command;
	logic [PORT_W-1:0] port;
	logic [DATA_W-1:0] wdata;

	modport source (output valid, output command, output port, output wdata, input ready);
	modport sink   (input valid, input command, input port, input wdata, output ready);
endinterface

`default_nettype wire

// ===== design/vgarpf_rsp_if.sv =====
// Response channel of the VGA register port file: one result per access.
// Depends on vgarpf_pkg.
`default_nettype none

interface vgarpf_rsp_if;
	import vgarpf_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] rdata;
	logic              port_decoded;

	modport source (output valid, output rdata, output port_decoded, input ready);
	modport sink   (input valid, input rdata, input port_decoded, output ready);
endinterface

`default_nettype wire

// ===== design/vga_register_port_file_top.sv =====
// Top level of the VGA register port file: index/data banks in one register
// memory, attribute flip-flop, DAC write path and palette memory.
// Depends on vgarpf_pkg, vgarpf_req_if, vgarpf_rsp_if.
//
//  channel | direction | payload                  | accepted when
//  req     | in        | command, port, wdata     | req.valid && req.ready
//  rsp     | out       | rdata, port_decoded      | rsp.valid && rsp.ready
//
// One item per cycle sustained while rsp is not stalled; an access is held as the
// item in flight (register memory read as it is taken), then in the output register.
// The single read port of the register memory sets the figure.
// Reset clears all index and control registers and the per-entry valid bits of the
// register memory, so banks read zero until written; no clearing pass.
// A stalled rsp holds the item in flight, and req.ready drops while one is held.
`default_nettype none

module vga_register_port_file_top (
	input wire logic     clk,
	input wire logic     arst_n,
	vgarpf_req_if.sink   req,
	vgarpf_rsp_if.source rsp
);
	import vgarpf_pkg::*;

	logic [DATA_W-1:0]  misc_q;
	logic [DATA_W-1:0]  seq_idx_q;
	logic [DATA_W-1:0]  crtc_idx_q;
	logic [DATA_W-1:0]  gc_idx_q;
	logic [ATTR_IW-1:0] attr_idx_q;
	logic               attr_ff_q;
	logic [DATA_W-1:0]  dac_idx_q;
	dac_comp_t          dac_comp_q;
	logic [2*COMP_W-1:0] dac_rg_q;
	logic               crtc_prot_q;

	logic [DATA_W-1:0]    regs_mem [REG_TOTAL];
	logic [3*COMP_W-1:0]  pal_mem  [PALETTE_DEPTH];
	logic [REG_TOTAL-1:0] vld_q;
	logic [DATA_W-1:0]    mem_rd_s1;

	logic       s1_valid_q;
	s1_info_t   s1_q;
	s1_info_t   s1_d;
	logic       out_valid_q;
	logic [DATA_W-1:0] rdata_q;
	logic       dec_q;

	logic       adv;
	logic       acc;
	logic       wr;
	logic       mem_we;
	logic       mem_re;
	logic [REG_AW-1:0] maddr;
	logic       in_rng;
	logic       crtc_locked;
	logic       pal_we;
	logic [COMP_W-1:0] comp;

	assign adv       = !out_valid_q || rsp.ready;
	assign req.ready = !s1_valid_q || adv;
	assign acc       = req.valid && req.ready;
	assign wr        = (req.command == CMD_WRITE);
	assign comp      = req.wdata[COMP_W-1:0];

	assign crtc_locked = CRTC_LOCK_EN && crtc_prot_q && (crtc_idx_q < CRTC_LOCK_LIMIT);

	// decode: register memory address and enables, range check, palette write and direct read value
	always_comb begin
		maddr     = '0;
		in_rng    = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		pal_we    = 1'b0;
		s1_d      = '0;
		s1_d.dec  = 1'b1;
		case (req.port)
			PORT_ATTR: begin
				in_rng = ({3'b0, attr_idx_q[4:0]} < DATA_W'(ATTR_COUNT));
				maddr  = REG_AW'(ATTR_BASE) + REG_AW'(attr_idx_q[4:0]);
				mem_we = wr && attr_ff_q && in_rng;
				if (!wr) s1_d.direct = DATA_W'(attr_idx_q);
			end
			PORT_ATTR_DATA: begin
				in_rng = ({3'b0, attr_idx_q[4:0]} < DATA_W'(ATTR_COUNT));
				maddr  = REG_AW'(ATTR_BASE) + REG_AW'(attr_idx_q[4:0]);
				mem_re = !wr && in_rng;
			end
			PORT_MISC_WR, PORT_DAC_WIDX, PORT_MISC_RD, PORT_SEQ_IDX, PORT_GC_IDX,
			PORT_CRTC_IDX, PORT_STATUS1: begin
				if (!wr) begin
					case (req.port)
						PORT_DAC_WIDX: s1_d.direct = dac_idx_q;
						PORT_MISC_RD:  s1_d.direct = misc_q;
						PORT_SEQ_IDX:  s1_d.direct = seq_idx_q;
						PORT_GC_IDX:   s1_d.direct = gc_idx_q;
						PORT_CRTC_IDX: s1_d.direct = crtc_idx_q;
						default:       s1_d.direct = '0;
					endcase
				end
			end
			PORT_DAC_DATA: begin
				pal_we = wr && (dac_comp_q == DAC_BLUE) &&
					({1'b0, dac_idx_q} < (DATA_W+1)'(PALETTE_DEPTH));
			end
			PORT_SEQ_DATA: begin
				in_rng = (seq_idx_q < DATA_W'(SEQ_COUNT));
				maddr  = REG_AW'(SEQ_BASE) + REG_AW'(seq_idx_q);
				mem_we = wr && in_rng;
				mem_re = !wr && in_rng;
			end
			PORT_GC_DATA: begin
				in_rng = (gc_idx_q < DATA_W'(GC_COUNT));
				maddr  = REG_AW'(GC_BASE) + REG_AW'(gc_idx_q);
				mem_we = wr && in_rng;
				mem_re = !wr && in_rng;
			end
			PORT_CRTC_DATA: begin
				in_rng = (crtc_idx_q < DATA_W'(CRTC_COUNT));
				maddr  = REG_AW'(CRTC_BASE) + REG_AW'(crtc_idx_q);
				mem_we = wr && in_rng && !crtc_locked;
				mem_re = !wr && in_rng;
			end
			default: s1_d.dec = 1'b0;
		endcase
		s1_d.from_mem = mem_re;
		s1_d.hit      = vld_q[maddr];
	end

	// register memory and palette
	always_ff @(posedge clk) begin
		if (acc && mem_we) regs_mem[maddr] <= req.wdata;
		if (acc && mem_re) mem_rd_s1 <= regs_mem[maddr];
		if (acc && pal_we) pal_mem[dac_idx_q[PAL_AW-1:0]] <= {dac_rg_q, comp};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (acc && mem_we) begin
			vld_q[maddr] <= 1'b1;
		end
	end

	// index, flip-flop and DAC control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			misc_q      <= '0;
			seq_idx_q   <= '0;
			crtc_idx_q  <= '0;
			gc_idx_q    <= '0;
			attr_idx_q  <= '0;
			attr_ff_q   <= 1'b0;
			dac_idx_q   <= '0;
			dac_comp_q  <= DAC_RED;
			dac_rg_q    <= '0;
			crtc_prot_q <= 1'b0;
		end else if (acc) begin
			case (req.port)
				PORT_ATTR: begin
					if (wr) begin
						if (!attr_ff_q) attr_idx_q <= req.wdata[ATTR_IW-1:0];
						attr_ff_q <= !attr_ff_q;
					end
				end
				PORT_MISC_WR:  if (wr) misc_q <= req.wdata;
				PORT_SEQ_IDX:  if (wr) seq_idx_q <= req.wdata;
				PORT_GC_IDX:   if (wr) gc_idx_q <= req.wdata;
				PORT_CRTC_IDX: if (wr) crtc_idx_q <= req.wdata;
				PORT_CRTC_DATA: begin
					// shadow of the protect bit; index 0x11 is never itself locked
					if (wr && CRTC_LOCK_EN && crtc_idx_q == CRTC_PROTECT_REG)
						crtc_prot_q <= req.wdata[CRTC_PROTECT_BIT];
				end
				PORT_DAC_WIDX: begin
					if (wr) begin
						dac_idx_q  <= req.wdata;
						dac_comp_q <= DAC_RED;
					end
				end
				PORT_DAC_DATA: begin
					if (wr) begin
						case (dac_comp_q)
							DAC_RED: begin
								dac_rg_q[2*COMP_W-1:COMP_W] <= comp;
								dac_comp_q <= DAC_GREEN;
							end
							DAC_GREEN: begin
								dac_rg_q[COMP_W-1:0] <= comp;
								dac_comp_q <= DAC_BLUE;
							end
							default: begin
								dac_idx_q  <= dac_idx_q + DATA_W'(1);
								dac_comp_q <= DAC_RED;
							end
						endcase
					end
				end
				PORT_STATUS1: if (!wr) attr_ff_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// item in flight and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc)
				s1_valid_q <= 1'b1;
			else if (adv)
				s1_valid_q <= 1'b0;
			if (adv)
				out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) s1_q <= s1_d;
		if (adv && s1_valid_q) begin
			rdata_q <= s1_q.from_mem ? (s1_q.hit ? mem_rd_s1 : '0) : s1_q.direct;
			dec_q   <= s1_q.dec;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.rdata        = rdata_q;
	assign rsp.port_decoded = dec_q;

	// a held item must not be overwritten by a new access
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !adv |-> !acc)
		else $error("access taken while item in flight is stalled");

	// every register memory write marks its entry valid
	a_vld_set: assert property (@(posedge clk) disable iff (!arst_n)
		acc && mem_we |=> vld_q[$past(maddr)])
		else $error("register memory entry not marked valid after write");

	// a status read puts the attribute flip-flop back into index phase
	a_ff_clear: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !wr && req.port == PORT_STATUS1 |=> !attr_ff_q)
		else $error("attribute flip-flop not cleared by status read");

	// memory reads and writes never come from the same access
	a_rw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("register memory read and write decoded together");

	// DAC sequencer only ever holds red, green or blue
	a_dac_comp: assert property (@(posedge clk) disable iff (!arst_n)
		dac_comp_q == DAC_RED || dac_comp_q == DAC_GREEN || dac_comp_q == DAC_BLUE)
		else $error("DAC component sequencer out of range");

endmodule

`default_nettype wire
